// ----- rtl/dxt_pkg.sv -----
package dxt_pkg;

  localparam int MAX_DIM_DEF = 16384;
  localparam int CFG_W       = 15;
  localparam int COORD_W     = 14;
  localparam int FIFO_DEPTH  = 2;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // floor(x/d) as (x*M) >> S, exact over the ranges used here
  localparam int DIV3_MUL = 683;
  localparam int DIV3_SH  = 11;
  localparam int DIV5_MUL = 1639;
  localparam int DIV5_SH  = 13;
  localparam int DIV7_MUL = 2341;
  localparam int DIV7_SH  = 14;

  typedef enum logic [1:0] {
    MODE_DXT1 = 2'd0,
    MODE_DXT3 = 2'd1,
    MODE_DXT5 = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]       fmt;
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    mode_e              mode;
    logic               cutout;
    rgb_t [3:0]         pal;
    logic [7:0][7:0]    ramp;
    logic [63:0]        aw;
    logic [31:0]        sel;
    logic [15:0]        mask;
    logic [COORD_W-1:0] base_x;
    logic [COORD_W-1:0] base_y;
  } entry_t;

  function automatic logic [31:0][7:0] build_exp5();
    logic [31:0][7:0] t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 8'((i * 255) / 31);
    end
    return t;
  endfunction

  function automatic logic [63:0][7:0] build_exp6();
    logic [63:0][7:0] t;
    for (int i = 0; i < 64; i++) begin
      t[i] = 8'((i * 255) / 63);
    end
    return t;
  endfunction

  localparam logic [31:0][7:0] EXP5 = build_exp5();
  localparam logic [63:0][7:0] EXP6 = build_exp6();

  function automatic mode_e decode_fmt(logic [1:0] f);
    mode_e m;
    case (f)
      2'd0:    m = MODE_DXT1;
      2'd1:    m = MODE_DXT3;
      default: m = MODE_DXT5;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] div3(logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'(DIV3_MUL);
    return p[DIV3_SH +: 8];
  endfunction

  function automatic logic [7:0] div5(logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'(DIV5_MUL);
    return p[DIV5_SH +: 8];
  endfunction

  function automatic logic [7:0] div7(logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'(DIV7_MUL);
    return p[DIV7_SH +: 8];
  endfunction

endpackage

// ----- rtl/dxt_fifo.sv -----
module dxt_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dxt_pkg::entry_t  push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output dxt_pkg::entry_t  pop_data_o,
  output logic             empty_o
);

  localparam int Depth = dxt_pkg::FIFO_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  dxt_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/dxt_front.sv -----
module dxt_front #(
  parameter int MAX_DIM = dxt_pkg::MAX_DIM_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dxt_pkg::cfg_t    cfg_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [63:0]      alpha_word_i,
  input  logic [63:0]      color_word_i,
  output logic             push_o,
  output dxt_pkg::entry_t  entry_o,
  input  logic             full_i
);

  localparam int DimW   = ($clog2(MAX_DIM + 1) > dxt_pkg::CFG_W) ?
                          $clog2(MAX_DIM + 1) : dxt_pkg::CFG_W;
  localparam int BlkMax = (MAX_DIM + 3) / 4;
  localparam int ColW   = (BlkMax > 1) ? $clog2(BlkMax) : 1;
  localparam int CmpW   = ((DimW > ColW + 2) ? DimW : ColW + 2) + 1;
  localparam int CW     = dxt_pkg::COORD_W;

  typedef struct packed {
    dxt_pkg::mode_e     mode;
    logic               four;
    dxt_pkg::rgb_t      e0;
    dxt_pkg::rgb_t      e1;
    logic               agt;
    logic [5:0][10:0]   sums;
    logic [63:0]        aw;
    logic [31:0]        sel;
    logic [15:0]        mask;
    logic [CW-1:0]      base_x;
    logic [CW-1:0]      base_y;
  } s1_t;

  logic [ColW-1:0] col_q, col_d;
  logic [ColW-1:0] row_q, row_d;
  logic            s1_v_q, s1_v_d;
  s1_t             s1_q, s1_d;

  logic [DimW-1:0] w_dim, h_dim;
  logic [CmpW-1:0] bx_cnt, by_cnt, xb, yb, col_inc, row_inc;
  logic [3:0]      xok, yok;
  logic            s1_free, accept;
  logic [15:0]     c0, c1;
  logic [7:0]      a0, a1;
  dxt_pkg::mode_e  mode;

  always_comb begin
    w_dim = DimW'(cfg_i.width);
    h_dim = DimW'(cfg_i.height);
    if (cfg_i.width == '0) begin
      w_dim = DimW'(1);
    end else if (DimW'(cfg_i.width) > DimW'(MAX_DIM)) begin
      w_dim = DimW'(MAX_DIM);
    end
    if (cfg_i.height == '0) begin
      h_dim = DimW'(1);
    end else if (DimW'(cfg_i.height) > DimW'(MAX_DIM)) begin
      h_dim = DimW'(MAX_DIM);
    end
  end

  assign bx_cnt  = (CmpW'(w_dim) + CmpW'(3)) >> 2;
  assign by_cnt  = (CmpW'(h_dim) + CmpW'(3)) >> 2;
  assign xb      = CmpW'({col_q, 2'b00});
  assign yb      = CmpW'({row_q, 2'b00});
  assign col_inc = CmpW'(col_q) + CmpW'(1);
  assign row_inc = CmpW'(row_q) + CmpW'(1);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      xok[i] = (xb + CmpW'(i)) < CmpW'(w_dim);
      yok[i] = (yb + CmpW'(i)) < CmpW'(h_dim);
    end
  end

  assign s1_free    = !s1_v_q || (s1_q.mask == '0) || !full_i;
  assign in_stall_o = !s1_free;
  assign accept     = in_valid_i && s1_free;
  assign push_o     = s1_v_q && (s1_q.mask != '0) && !full_i;

  assign c0   = color_word_i[15:0];
  assign c1   = color_word_i[31:16];
  assign a0   = alpha_word_i[7:0];
  assign a1   = alpha_word_i[15:8];
  assign mode = dxt_pkg::decode_fmt(cfg_i.fmt);

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    s1_v_d = accept ? 1'b1 : (s1_free ? 1'b0 : s1_v_q);
    s1_d   = s1_q;
    if (accept) begin
      if (col_inc >= bx_cnt) begin
        col_d = '0;
        row_d = (row_inc >= by_cnt) ? '0 : ColW'(row_inc);
      end else begin
        col_d = ColW'(col_inc);
      end
      s1_d.mode   = mode;
      s1_d.four   = (mode == dxt_pkg::MODE_DXT3) || (c0 > c1);
      s1_d.e0     = {dxt_pkg::EXP5[c0[15:11]], dxt_pkg::EXP6[c0[10:5]],
                     dxt_pkg::EXP5[c0[4:0]]};
      s1_d.e1     = {dxt_pkg::EXP5[c1[15:11]], dxt_pkg::EXP6[c1[10:5]],
                     dxt_pkg::EXP5[c1[4:0]]};
      s1_d.agt    = a0 > a1;
      for (int k = 1; k <= 6; k++) begin
        if (a0 > a1) begin
          s1_d.sums[k-1] = 11'(a0) * 11'(7 - k) + 11'(a1) * 11'(k);
        end else if (k <= 4) begin
          s1_d.sums[k-1] = 11'(a0) * 11'(5 - k) + 11'(a1) * 11'(k);
        end else begin
          s1_d.sums[k-1] = '0;
        end
      end
      s1_d.aw     = alpha_word_i;
      s1_d.sel    = color_word_i[63:32];
      for (int j = 0; j < 4; j++) begin
        for (int i = 0; i < 4; i++) begin
          s1_d.mask[4*j + i] = xok[i] && yok[j];
        end
      end
      s1_d.base_x = CW'({col_q, 2'b00});
      s1_d.base_y = CW'({row_q, 2'b00});
    end
  end

  // palette and alpha ramp finish
  always_comb begin
    entry_o.mode   = s1_q.mode;
    entry_o.cutout = (s1_q.mode == dxt_pkg::MODE_DXT1) && !s1_q.four;
    entry_o.pal[0] = s1_q.e0;
    entry_o.pal[1] = s1_q.e1;
    if (s1_q.four) begin
      entry_o.pal[2].r = dxt_pkg::div3({1'b0, s1_q.e0.r, 1'b0} + 10'(s1_q.e1.r));
      entry_o.pal[2].g = dxt_pkg::div3({1'b0, s1_q.e0.g, 1'b0} + 10'(s1_q.e1.g));
      entry_o.pal[2].b = dxt_pkg::div3({1'b0, s1_q.e0.b, 1'b0} + 10'(s1_q.e1.b));
      entry_o.pal[3].r = dxt_pkg::div3(10'(s1_q.e0.r) + {1'b0, s1_q.e1.r, 1'b0});
      entry_o.pal[3].g = dxt_pkg::div3(10'(s1_q.e0.g) + {1'b0, s1_q.e1.g, 1'b0});
      entry_o.pal[3].b = dxt_pkg::div3(10'(s1_q.e0.b) + {1'b0, s1_q.e1.b, 1'b0});
    end else begin
      entry_o.pal[2].r = 8'((9'(s1_q.e0.r) + 9'(s1_q.e1.r)) >> 1);
      entry_o.pal[2].g = 8'((9'(s1_q.e0.g) + 9'(s1_q.e1.g)) >> 1);
      entry_o.pal[2].b = 8'((9'(s1_q.e0.b) + 9'(s1_q.e1.b)) >> 1);
      entry_o.pal[3]   = '0;
    end
    entry_o.ramp[0] = s1_q.aw[7:0];
    entry_o.ramp[1] = s1_q.aw[15:8];
    for (int k = 1; k <= 6; k++) begin
      if (s1_q.agt) begin
        entry_o.ramp[1+k] = dxt_pkg::div7(s1_q.sums[k-1]);
      end else if (k <= 4) begin
        entry_o.ramp[1+k] = dxt_pkg::div5(s1_q.sums[k-1]);
      end else if (k == 5) begin
        entry_o.ramp[1+k] = 8'd0;
      end else begin
        entry_o.ramp[1+k] = 8'd255;
      end
    end
    entry_o.aw     = s1_q.aw;
    entry_o.sel    = s1_q.sel;
    entry_o.mask   = s1_q.mask;
    entry_o.base_x = s1_q.base_x;
    entry_o.base_y = s1_q.base_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

endmodule

// ----- rtl/dxt_back.sv -----
module dxt_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fifo_empty_i,
  input  dxt_pkg::entry_t              fifo_data_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [dxt_pkg::COORD_W-1:0]  pixel_x_o,
  output logic [dxt_pkg::COORD_W-1:0]  pixel_y_o,
  output logic [7:0]                   red_o,
  output logic [7:0]                   green_o,
  output logic [7:0]                   blue_o,
  output logic [7:0]                   alpha_o,
  output logic                         last_o
);

  localparam int CW = dxt_pkg::COORD_W;

  logic            cur_v_q, cur_v_d;
  dxt_pkg::entry_t cur_q, cur_d;
  logic [15:0]     rem_q, rem_d, rem_next;
  logic            out_v_q, out_v_d;
  logic [CW-1:0]   px_q, px_d, py_q, py_d;
  dxt_pkg::rgb_t   rgb_q, rgb_d;
  logic [7:0]      a_q, a_d;
  logic            last_q, last_d;

  logic [3:0]      idx;
  logic [1:0]      code;
  logic [3:0]      nib;
  logic [2:0]      aidx;
  logic [7:0]      alpha;
  logic            out_ready, emit, is_last;

  always_comb begin
    idx = '0;
    for (int i = 15; i >= 0; i--) begin
      if (rem_q[i]) begin
        idx = 4'(i);
      end
    end
  end

  assign rem_next  = rem_q & ~(16'd1 << idx);
  assign is_last   = (rem_next == '0);
  assign out_ready = !out_v_q || !out_stall_i;
  assign emit      = cur_v_q && out_ready;
  assign pop_o     = !fifo_empty_i && (!cur_v_q || (emit && is_last));

  assign code = cur_q.sel[2*idx +: 2];
  assign nib  = cur_q.aw[4*idx +: 4];
  assign aidx = cur_q.aw[16 + 3*idx +: 3];

  always_comb begin
    case (cur_q.mode)
      dxt_pkg::MODE_DXT1: alpha = (cur_q.cutout && code == 2'd3) ? 8'd0 : 8'd255;
      dxt_pkg::MODE_DXT3: alpha = {nib, nib};
      default:            alpha = cur_q.ramp[aidx];
    endcase
  end

  always_comb begin
    cur_v_d = cur_v_q;
    cur_d   = cur_q;
    rem_d   = rem_q;
    if (emit) begin
      rem_d = rem_next;
      if (is_last) begin
        cur_v_d = 1'b0;
      end
    end
    if (pop_o) begin
      cur_v_d = 1'b1;
      cur_d   = fifo_data_i;
      rem_d   = fifo_data_i.mask;
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    px_d    = px_q;
    py_d    = py_q;
    rgb_d   = rgb_q;
    a_d     = a_q;
    last_d  = last_q;
    if (emit) begin
      out_v_d = 1'b1;
      px_d    = {cur_q.base_x[CW-1:2], idx[1:0]};
      py_d    = {cur_q.base_y[CW-1:2], idx[3:2]};
      rgb_d   = cur_q.pal[code];
      a_d     = alpha;
      last_d  = is_last;
    end else if (!out_stall_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      cur_v_q <= cur_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    rem_q  <= rem_d;
    px_q   <= px_d;
    py_q   <= py_d;
    rgb_q  <= rgb_d;
    a_q    <= a_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_v_q;
  assign pixel_x_o   = px_q;
  assign pixel_y_o   = py_q;
  assign red_o       = rgb_q.r;
  assign green_o     = rgb_q.g;
  assign blue_o      = rgb_q.b;
  assign alpha_o     = a_q;
  assign last_o      = last_q;

endmodule

// ----- rtl/dxt_texture_block_decoder_unit.sv -----
// DXT1/DXT3/DXT5 block decoder. One compressed 4x4 block enters per word on
// the input channel, in raster block order; the unit emits one RGBA texel per
// cycle while out_stall_i is low, with its image coordinates, raster order
// inside the block, last set on the final texel of the block. Texels beyond
// the configured width or height are dropped, and a block wholly outside the
// image gives no output. A full block gives 16 texels, a partial block only
// those inside the image. The front end takes a new block every cycle while
// its two-entry queue has room, so a following block is decoded while the
// current one is still being emitted. A block passes the front-end register,
// the queue and the current-block register before reaching the output
// register. Write configuration only while the unit is idle.
module dxt_texture_block_decoder_unit #(
  parameter int MAX_DIM = dxt_pkg::MAX_DIM_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [dxt_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [63:0]                  alpha_word_i,
  input  logic [63:0]                  color_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [dxt_pkg::COORD_W-1:0]  pixel_x_o,
  output logic [dxt_pkg::COORD_W-1:0]  pixel_y_o,
  output logic [7:0]                   red_o,
  output logic [7:0]                   green_o,
  output logic [7:0]                   blue_o,
  output logic [7:0]                   alpha_o,
  output logic                         last_o
);

  dxt_pkg::cfg_t   cfg_q, cfg_d;
  dxt_pkg::entry_t push_data, pop_data;
  logic            push, pop, full, empty;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        dxt_pkg::REG_FORMAT: cfg_d.fmt    = cfg_data_i[1:0];
        dxt_pkg::REG_WIDTH:  cfg_d.width  = cfg_data_i;
        dxt_pkg::REG_HEIGHT: cfg_d.height = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fmt    <= 2'd0;
      cfg_q.width  <= dxt_pkg::CFG_W'(1);
      cfg_q.height <= dxt_pkg::CFG_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dxt_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .alpha_word_i (alpha_word_i),
    .color_word_i (color_word_i),
    .push_o       (push),
    .entry_o      (push_data),
    .full_i       (full)
  );

  dxt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  dxt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (empty),
    .fifo_data_i  (pop_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_o      (alpha_o),
    .last_o       (last_o)
  );

endmodule

// ----- rtl/dxt_checker.sv -----
module dxt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [13:0] pixel_x_o,
  input logic [13:0] pixel_y_o,
  input logic [7:0]  red_o,
  input logic [7:0]  green_o,
  input logic [7:0]  blue_o,
  input logic [7:0]  alpha_o,
  input logic        last_o
);

  logic out_acc;
  assign out_acc = out_valid_o && !out_stall_i;

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output word valid during reset");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled output word dropped");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pixel_x_o) && $stable(pixel_y_o) &&
      $stable(red_o) && $stable(green_o) && $stable(blue_o) &&
      $stable(alpha_o) && $stable(last_o))
    else $error("stalled output word changed");

  // a texel that is not last is followed by one of the same block, later in raster order
  a_same_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !last_o |=> !out_valid_o ||
      (pixel_x_o[13:2] == $past(pixel_x_o[13:2]) &&
       pixel_y_o[13:2] == $past(pixel_y_o[13:2]) &&
       {pixel_y_o[1:0], pixel_x_o[1:0]} > $past({pixel_y_o[1:0], pixel_x_o[1:0]})))
    else $error("texel order broken inside a block");

endmodule

bind dxt_texture_block_decoder_unit dxt_checker u_dxt_checker (.*);

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE       = 24;
  localparam int unsigned RANDOM_ITEMS = 336;
  localparam int unsigned DIM_LIMIT    = dxt_pkg::MAX_DIM_DEF;
  localparam logic [1:0]  FMT_UNUSED   = 2'd3;

  typedef enum int {
    STALL_NONE,
    STALL_SPARSE,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_kind_e;

  typedef struct packed {
    logic [dxt_pkg::COORD_W-1:0] x;
    logic [dxt_pkg::COORD_W-1:0] y;
    logic [7:0]                  r;
    logic [7:0]                  g;
    logic [7:0]                  b;
    logic [7:0]                  a;
    logic                        last;
  } texel_t;

  logic                        clk          = 1'b0;
  logic                        rst_ni;
  logic                        cfg_valid_i  = 1'b0;
  logic                        cfg_ready_o;
  logic [1:0]                  cfg_index_i  = dxt_pkg::REG_FORMAT;
  logic [dxt_pkg::CFG_W-1:0]   cfg_data_i   = '0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_stall_o;
  logic [63:0]                 alpha_word_i = '0;
  logic [63:0]                 color_word_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i  = 1'b0;
  logic [dxt_pkg::COORD_W-1:0] pixel_x_o;
  logic [dxt_pkg::COORD_W-1:0] pixel_y_o;
  logic [7:0]                  red_o;
  logic [7:0]                  green_o;
  logic [7:0]                  blue_o;
  logic [7:0]                  alpha_o;
  logic                        last_o;

  // decoder model state
  logic [1:0]   cur_format;
  int unsigned  cur_width;
  int unsigned  cur_height;
  int unsigned  block_col;
  int unsigned  block_row;

  texel_t       expected_texels [$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count    = 0;
  int unsigned  burst_left     = 0;
  int unsigned  random_blocks  = 0;

  stall_kind_e  stall_kind  = STALL_NONE;
  int unsigned  stall_left  = 0;
  int unsigned  stall_phase = 0;

  dxt_texture_block_decoder_unit DUT (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .alpha_word_i (alpha_word_i),
    .color_word_i (color_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_o      (alpha_o),
    .last_o       (last_o)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_kind = stall_kind_e'($urandom_range(0, 3));
        stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      stall_phase++;
      case (stall_kind)
        STALL_NONE:     out_stall_i <= 1'b0;
        STALL_SPARSE:   out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_PERIODIC: out_stall_i <= ((stall_phase % 7) < 3);
        default:        out_stall_i <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    $display("cycle %0d: %s got %0d expected %0d", cycle_count, field, got, want);
  endtask

  task automatic check_texel();
    texel_t want;
    if (expected_texels.size() == 0) begin
      report_mismatch("unexpected texel at x", 32'(pixel_x_o), 0);
    end else begin
      want = expected_texels.pop_front();
      if (pixel_x_o !== want.x) report_mismatch("pixel_x", 32'(pixel_x_o), 32'(want.x));
      if (pixel_y_o !== want.y) report_mismatch("pixel_y", 32'(pixel_y_o), 32'(want.y));
      if (red_o !== want.r)     report_mismatch("red", 32'(red_o), 32'(want.r));
      if (green_o !== want.g)   report_mismatch("green", 32'(green_o), 32'(want.g));
      if (blue_o !== want.b)    report_mismatch("blue", 32'(blue_o), 32'(want.b));
      if (alpha_o !== want.a)   report_mismatch("alpha", 32'(alpha_o), 32'(want.a));
      if (last_o !== want.last) report_mismatch("last", 32'(last_o), 32'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_texel();
  end

  function automatic int unsigned clamp_dim(input int unsigned v);
    if (v == 0) return 1;
    if (v > DIM_LIMIT) return DIM_LIMIT;
    return v;
  endfunction

  task automatic apply_reg(input logic [1:0] idx,
                           input logic [dxt_pkg::CFG_W-1:0] data);
    if (idx == dxt_pkg::REG_FORMAT) cur_format = data[1:0];
    else if (idx == dxt_pkg::REG_WIDTH) cur_width = 32'(data);
    else if (idx == dxt_pkg::REG_HEIGHT) cur_height = 32'(data);
  endtask

  task automatic decode_block(input logic [63:0] aw, input logic [63:0] cw);
    int unsigned w, h, bx_n, by_n, c0, c1, c, px, py, a, n, a0, a1;
    int unsigned pal [4][3];
    int unsigned pal_a [4];
    int unsigned ramp [8];
    logic [31:0] sel;
    logic [1:0] code;
    logic [2:0] aidx;
    bit four;
    dxt_pkg::mode_e mode;
    texel_t blk [16];
    w    = clamp_dim(cur_width);
    h    = clamp_dim(cur_height);
    bx_n = (w + 3) / 4;
    by_n = (h + 3) / 4;
    c0   = 32'(cw[15:0]);
    c1   = 32'(cw[31:16]);
    sel  = cw[63:32];
    if (cur_format == dxt_pkg::MODE_DXT1) mode = dxt_pkg::MODE_DXT1;
    else if (cur_format == dxt_pkg::MODE_DXT3) mode = dxt_pkg::MODE_DXT3;
    else mode = dxt_pkg::MODE_DXT5;
    four = (mode == dxt_pkg::MODE_DXT3) || (c0 > c1);
    for (int e = 0; e < 2; e++) begin
      c = (e == 0) ? c0 : c1;
      pal[e][0] = ((c >> 11) & 'h1F) * 255 / 31;
      pal[e][1] = ((c >> 5) & 'h3F) * 255 / 63;
      pal[e][2] = (c & 'h1F) * 255 / 31;
    end
    for (int ch = 0; ch < 3; ch++) begin
      if (four) begin
        pal[2][ch] = (2 * pal[0][ch] + pal[1][ch]) / 3;
        pal[3][ch] = (pal[0][ch] + 2 * pal[1][ch]) / 3;
      end else begin
        pal[2][ch] = (pal[0][ch] + pal[1][ch]) / 2;
        pal[3][ch] = 0;
      end
    end
    for (int k = 0; k < 4; k++) pal_a[k] = 255;
    if (!four && mode == dxt_pkg::MODE_DXT1) pal_a[3] = 0;
    a0 = 32'(aw[7:0]);
    a1 = 32'(aw[15:8]);
    ramp[0] = a0;
    ramp[1] = a1;
    if (a0 > a1) begin
      for (int k = 1; k <= 6; k++) ramp[1 + k] = ((7 - k) * a0 + k * a1) / 7;
    end else begin
      for (int k = 1; k <= 4; k++) ramp[1 + k] = ((5 - k) * a0 + k * a1) / 5;
      ramp[6] = 0;
      ramp[7] = 255;
    end
    n = 0;
    for (int i = 0; i < 16; i++) begin
      px   = block_col * 4 + (i & 3);
      py   = block_row * 4 + (i >> 2);
      code = sel[2 * i +: 2];
      aidx = aw[16 + 3 * i +: 3];
      if (px < w && py < h) begin
        if (mode == dxt_pkg::MODE_DXT1) a = pal_a[code];
        else if (mode == dxt_pkg::MODE_DXT3) a = 32'(aw[4 * i +: 4]) * 17;
        else a = ramp[aidx];
        blk[n].x    = dxt_pkg::COORD_W'(px);
        blk[n].y    = dxt_pkg::COORD_W'(py);
        blk[n].r    = 8'(pal[code][0]);
        blk[n].g    = 8'(pal[code][1]);
        blk[n].b    = 8'(pal[code][2]);
        blk[n].a    = 8'(a);
        blk[n].last = 1'b0;
        n++;
      end
    end
    if (n > 0) blk[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_texels.push_back(blk[i]);
    block_col++;
    if (block_col >= bx_n) begin
      block_col = 0;
      block_row++;
      if (block_row >= by_n) block_row = 0;
    end
  endtask

  // entered and left at a falling edge
  task automatic send_block(input logic [63:0] aw, input logic [63:0] cw);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    alpha_word_i <= aw;
    color_word_i <= cw;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    decode_block(aw, cw);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_texels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_config(input logic [1:0] fmt, input int unsigned wd,
                            input int unsigned ht);
    logic [1:0] regs [3];
    logic [dxt_pkg::CFG_W-1:0] vals [3];
    regs = '{dxt_pkg::REG_FORMAT, dxt_pkg::REG_WIDTH, dxt_pkg::REG_HEIGHT};
    vals = '{dxt_pkg::CFG_W'(fmt), dxt_pkg::CFG_W'(wd), dxt_pkg::CFG_W'(ht)};
    wait_idle();
    for (int r = 0; r < 3; r++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[r];
      cfg_data_i  <= vals[r];
      @(posedge clk);
      while (!cfg_ready_o) @(posedge clk);
      apply_reg(regs[r], vals[r]);
      @(negedge clk);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic test_dxt1_modes();
    set_config(dxt_pkg::MODE_DXT1, 8, 8);
    send_block(rand_word(), {32'h1B1B_E4E4, 16'h001F, 16'hF800});
    send_block(rand_word(), {32'hFFFF_FFFF, 16'h7BEF, 16'h7BEF});
    send_block(64'h0, {32'hE4E4_E4E4, 16'hFFFF, 16'h0000});
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_dxt3_alpha();
    set_config(dxt_pkg::MODE_DXT3, 8, 8);
    send_block(64'h0, 64'h0);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, {32'hE4E4_E4E4, 16'hFFFF, 16'h0000});
    send_block(64'hFEDC_BA98_7654_3210, {32'h4E4E_1B1B, 16'h07E0, 16'h841F});
  endtask

  task automatic test_dxt5_ramps();
    logic [47:0] sel48;
    for (int i = 0; i < 16; i++) sel48[3 * i +: 3] = 3'(i % 8);
    set_config(dxt_pkg::MODE_DXT5, 8, 8);
    send_block({sel48, 8'h10, 8'hF0}, {32'hE4E4_E4E4, 16'h001F, 16'hF800});
    send_block({sel48, 8'hC8, 8'h20}, {32'hFFFF_FFFF, 16'hF800, 16'h001F});
    send_block({sel48, 8'h80, 8'h80}, rand_word());
    send_block({sel48, 8'h00, 8'hFF}, rand_word());
    send_block({sel48, 8'hFF, 8'h00}, rand_word());
  endtask

  task automatic test_unused_format();
    set_config(FMT_UNUSED, 8, 8);
    send_block(rand_word(), {32'hFFFF_FFFF, 16'h1234, 16'h1234});
  endtask

  task automatic test_dim_clamp();
    set_config(dxt_pkg::MODE_DXT1, 0, 0);
    send_block(rand_word(), rand_word());
    set_config(dxt_pkg::MODE_DXT3, 32767, DIM_LIMIT);
    send_block(rand_word(), rand_word());
    send_block(rand_word(), rand_word());
  endtask

  task automatic test_partial_blocks();
    set_config(dxt_pkg::MODE_DXT3, 6, 7);
    repeat (4) send_block(rand_word(), rand_word());
  endtask

  task automatic test_counters_beyond_frame();
    set_config(dxt_pkg::MODE_DXT1, 64, 64);
    repeat (2) send_block(rand_word(), rand_word());
    set_config(dxt_pkg::MODE_DXT5, 4, 4);
    repeat (2) send_block(rand_word(), rand_word());
  endtask

  function automatic int unsigned pick_dim();
    int unsigned pick;
    pick = $urandom_range(0, 11);
    case (pick)
      0:       return 0;
      1:       return DIM_LIMIT;
      2:       return DIM_LIMIT + 1;
      3:       return 32767;
      default: return $urandom_range(1, 48);
    endcase
  endfunction

  task automatic test_random_frames();
    int unsigned batch;
    while (random_blocks < RANDOM_ITEMS) begin
      set_config(2'($urandom_range(0, 3)), pick_dim(), pick_dim());
      batch = $urandom_range(10, 40);
      if (batch > RANDOM_ITEMS - random_blocks) batch = RANDOM_ITEMS - random_blocks;
      repeat (batch) begin
        send_block(rand_word(), rand_word());
        random_blocks++;
      end
    end
  endtask

  initial begin
    rst_ni     <= 1'b0;
    cur_format = dxt_pkg::MODE_DXT1;
    cur_width  = 1;
    cur_height = 1;
    block_col  = 0;
    block_row  = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    test_dxt1_modes();
    test_dxt3_alpha();
    test_dxt5_ramps();
    test_unused_format();
    test_dim_clamp();
    test_partial_blocks();
    test_counters_beyond_frame();
    test_random_frames();
    wait_idle();

    if (mismatch_count == 0 && expected_texels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
